>>> sv/lfrc_pkg.sv
`timescale 1ns / 1ps
// Package for the log frame replay checker: shared types, codes and the CRC-32 byte step.
// No dependencies; every module of the block imports it.
package lfrc_pkg;

    // Result queue depth (needs room for the two words one byte can cause)
    localparam int LFRC_RES_DEPTH = 4;

    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
    localparam logic [41:0] MIN_FRAME = 42'd12;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_GOOD    = 2'd1;
    localparam logic [1:0] KIND_STOP    = 2'd2;

    // Stop reasons
    localparam logic [1:0] STOP_BAD_MAGIC = 2'd0;
    localparam logic [1:0] STOP_PAST_END  = 2'd1;
    localparam logic [1:0] STOP_CRC_BAD   = 2'd2;
    localparam logic [1:0] STOP_EXHAUSTED = 2'd3;

    // Register select on the config port (paddr bit 3)
    localparam logic REG_REGION_SIZE = 1'b0;
    localparam logic REG_FRAME_MAGIC = 1'b1;

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_CRC,
        PH_STOPPED
    } phase_t;

    typedef struct packed {
        logic [39:0] region_size;
        logic [31:0] frame_magic;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [39:0] frame_seq;
        logic [1:0]  stop_reason;
        logic [39:0] good_frames;
        logic [39:0] resume_offset;
        logic        last;
    } res_t;

    // Reflected CRC-32 update by one byte, unrolled over its eight bits
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Assemble one result word, last flag clear
    function automatic res_t make_res(input logic [1:0] kind, input logic [7:0] pb,
                                      input logic [39:0] seq, input logic [1:0] reason,
                                      input logic [39:0] good, input logic [39:0] resume);
        res_t r;
        r.kind          = kind;
        r.payload_byte  = pb;
        r.frame_seq     = seq;
        r.stop_reason   = reason;
        r.good_frames   = good;
        r.resume_offset = resume;
        r.last          = 1'b0;
        return r;
    endfunction

endpackage

>>> sv/lfrc_regs.sv
`timescale 1ns / 1ps
// Configuration registers of the log frame replay checker behind an APB-style port.
// Depends on lfrc_pkg.
module lfrc_regs
    import lfrc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [39:0] region_size_reg;
    logic [31:0] frame_magic_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Write on the access cycle; registers sit 8 bytes apart
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_size_reg <= '0;
            frame_magic_reg <= '0;
        end else if (wr_en) begin
            case (paddr[3])
                REG_REGION_SIZE: region_size_reg <= pwdata[39:0];
                REG_FRAME_MAGIC: frame_magic_reg <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    // Read back the selected register
    always_comb begin
        case (paddr[3])
            REG_REGION_SIZE: prdata = {24'd0, region_size_reg};
            REG_FRAME_MAGIC: prdata = {32'd0, frame_magic_reg};
            default:         prdata = '0;
        endcase
    end

    assign cfg.region_size = region_size_reg;
    assign cfg.frame_magic = frame_magic_reg;

endmodule

>>> sv/lfrc_res_fifo.sv
`timescale 1ns / 1ps
// Result queue of the log frame replay checker: takes up to two words a cycle, gives one.
// Depends on lfrc_pkg.
module lfrc_res_fifo
    import lfrc_pkg::*;
#(
    parameter int DEPTH = LFRC_RES_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] push_cnt,
    input  res_t       push_data0,
    input  res_t       push_data1,
    output logic       room2,
    output logic       m_valid,
    input  logic       m_ready,
    output res_t       m_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    res_t            mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next, wr_ptr_p1;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            pop;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign pop       = m_valid && m_ready;
    assign m_valid   = (count_reg != '0);
    assign m_data    = mem[rd_ptr_reg];
    assign room2     = (count_reg <= CW'(DEPTH - 2));
    assign wr_ptr_p1 = ptr_inc(wr_ptr_reg);

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        case (push_cnt)
            2'd1:    wr_ptr_next = wr_ptr_p1;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_p1);
            default: ;
        endcase
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CW'(push_cnt) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed words
    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem[wr_ptr_reg] <= push_data0;
        end
        if (push_cnt == 2'd2) begin
            mem[wr_ptr_p1] <= push_data1;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push_cnt != 2'd0 |-> count_reg <= CW'(DEPTH - 32'(push_cnt)))
        else $error("result queue overflow");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("result queue count out of range");

    a_pop_moves_ptr: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> rd_ptr_reg != $past(rd_ptr_reg) || DEPTH == 1)
        else $error("read pointer did not advance on pop");

endmodule

>>> sv/lfrc_core.sv
`timescale 1ns / 1ps
// Deframer core of the log frame replay checker: input register, frame state and
// single-pass result generation with the CRC-32 check. Depends on lfrc_pkg.
module lfrc_core
    import lfrc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_region_byte,
    input  logic       room2,
    output logic [1:0] push_cnt,
    output res_t       res0,
    output res_t       res1
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    phase_t      phase_reg, phase_next;
    logic [1:0]  fbi_reg, fbi_next;
    logic [31:0] magic_shift_reg, magic_shift_next;
    logic [31:0] payload_length_reg, payload_length_next;
    logic [31:0] payload_left_reg, payload_left_next;
    logic [31:0] running_crc_reg, running_crc_next;
    logic [31:0] crc_field_reg, crc_field_next;
    logic [40:0] byte_offset_reg, byte_offset_next;
    logic [40:0] frame_start_reg, frame_start_next;
    logic [39:0] good_count_reg, good_count_next;

    logic        fire;
    logic [1:0]  n;
    res_t        r0, r1;

    logic [31:0] magic_sh, len_sh, crc_sh, crc_upd;
    logic [40:0] bo_inc;
    logic [39:0] gc_inc, gc_inc2;
    logic        exhausted_now, exhausted_after, past_region;

    assign fire    = in_valid_reg && room2;
    assign s_ready = !in_valid_reg || fire;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_region_byte;
        end
    end

    // Shared datapath terms
    assign magic_sh = {in_byte_reg, magic_shift_reg[31:8]};
    assign len_sh   = {in_byte_reg, payload_length_reg[31:8]};
    assign crc_sh   = {in_byte_reg, crc_field_reg[31:8]};
    assign crc_upd  = crc32_byte(running_crc_reg, in_byte_reg);
    assign bo_inc   = byte_offset_reg + 41'd1;
    assign gc_inc   = good_count_reg + 40'd1;
    assign gc_inc2  = good_count_reg + 40'd2;

    assign exhausted_now   = ({1'b0, frame_start_reg} + MIN_FRAME) > {2'b0, cfg.region_size};
    assign exhausted_after = ({1'b0, bo_inc} + MIN_FRAME) > {2'b0, cfg.region_size};
    assign past_region     = ({1'b0, frame_start_reg} + MIN_FRAME + {10'd0, len_sh})
                             > {2'b0, cfg.region_size};

    // Next state and results for the byte in the input register
    always_comb begin
        phase_next          = phase_reg;
        fbi_next            = fbi_reg;
        magic_shift_next    = magic_shift_reg;
        payload_length_next = payload_length_reg;
        payload_left_next   = payload_left_reg;
        running_crc_next    = running_crc_reg;
        crc_field_next      = crc_field_reg;
        byte_offset_next    = byte_offset_reg;
        frame_start_next    = frame_start_reg;
        good_count_next     = good_count_reg;
        n  = 2'd0;
        r0 = make_res(KIND_STOP, 8'd0, gc_inc, STOP_EXHAUSTED, good_count_reg,
                      frame_start_reg[39:0]);
        r1 = r0;

        case (phase_reg)
            PH_MAGIC: begin
                if (fbi_reg == 2'd0 && exhausted_now) begin
                    n          = 2'd1;
                    phase_next = PH_STOPPED;
                end else begin
                    magic_shift_next = magic_sh;
                    byte_offset_next = bo_inc;
                    fbi_next         = fbi_reg + 2'd1;
                    if (fbi_reg == 2'd3) begin
                        if (magic_sh != cfg.frame_magic) begin
                            n              = 2'd1;
                            r0.stop_reason = STOP_BAD_MAGIC;
                            phase_next     = PH_STOPPED;
                        end else begin
                            phase_next = PH_LENGTH;
                        end
                    end
                end
            end
            PH_LENGTH: begin
                payload_length_next = len_sh;
                byte_offset_next    = bo_inc;
                fbi_next            = fbi_reg + 2'd1;
                if (fbi_reg == 2'd3) begin
                    if (past_region) begin
                        n              = 2'd1;
                        r0.stop_reason = STOP_PAST_END;
                        phase_next     = PH_STOPPED;
                    end else begin
                        payload_left_next = len_sh;
                        running_crc_next  = CRC_INIT;
                        phase_next        = (len_sh != 32'd0) ? PH_PAYLOAD : PH_CRC;
                    end
                end
            end
            PH_PAYLOAD: begin
                running_crc_next  = crc_upd;
                byte_offset_next  = bo_inc;
                n                 = 2'd1;
                r0 = make_res(KIND_PAYLOAD, in_byte_reg, gc_inc, STOP_BAD_MAGIC,
                              good_count_reg, 40'd0);
                payload_left_next = payload_left_reg - 32'd1;
                if (payload_left_reg == 32'd1) begin
                    phase_next = PH_CRC;
                end
            end
            PH_CRC: begin
                crc_field_next   = crc_sh;
                byte_offset_next = bo_inc;
                fbi_next         = fbi_reg + 2'd1;
                if (fbi_reg == 2'd3) begin
                    if (crc_sh != ~running_crc_reg) begin
                        n              = 2'd1;
                        r0.stop_reason = STOP_CRC_BAD;
                        phase_next     = PH_STOPPED;
                    end else begin
                        good_count_next  = gc_inc;
                        frame_start_next = bo_inc;
                        running_crc_next = CRC_INIT;
                        phase_next       = PH_MAGIC;
                        n  = 2'd1;
                        r0 = make_res(KIND_GOOD, 8'd0, gc_inc, STOP_BAD_MAGIC, gc_inc, 40'd0);
                        // Region used up right after a good frame
                        if (exhausted_after) begin
                            n  = 2'd2;
                            r1 = make_res(KIND_STOP, 8'd0, gc_inc2, STOP_EXHAUSTED, gc_inc,
                                          bo_inc[39:0]);
                            phase_next = PH_STOPPED;
                        end
                    end
                end
            end
            default: ;
        endcase

        // Flag the last word of this byte
        if (n == 2'd1) begin
            r0.last = 1'b1;
        end
        if (n == 2'd2) begin
            r1.last = 1'b1;
        end
    end

    assign push_cnt = fire ? n : 2'd0;
    assign res0     = r0;
    assign res1     = r1;

    // Frame state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_MAGIC;
            fbi_reg            <= '0;
            magic_shift_reg    <= '0;
            payload_length_reg <= '0;
            payload_left_reg   <= '0;
            running_crc_reg    <= CRC_INIT;
            crc_field_reg      <= '0;
            byte_offset_reg    <= '0;
            frame_start_reg    <= '0;
            good_count_reg     <= '0;
        end else if (fire) begin
            phase_reg          <= phase_next;
            fbi_reg            <= fbi_next;
            magic_shift_reg    <= magic_shift_next;
            payload_length_reg <= payload_length_next;
            payload_left_reg   <= payload_left_next;
            running_crc_reg    <= running_crc_next;
            crc_field_reg      <= crc_field_next;
            byte_offset_reg    <= byte_offset_next;
            frame_start_reg    <= frame_start_next;
            good_count_reg     <= good_count_next;
        end
    end

    a_stop_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_STOPPED |=> phase_reg == PH_STOPPED)
        else $error("left stopped state without reset");

    a_pair_is_good_then_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        push_cnt == 2'd2 |-> res0.kind == KIND_GOOD && res1.kind == KIND_STOP && res1.last)
        else $error("two words from one byte must be good verdict then stop");

    a_single_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        push_cnt == 2'd1 |-> res0.last)
        else $error("single word not flagged last");

    a_stop_no_offset_move: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_STOPPED |=> $stable(byte_offset_reg) && $stable(good_count_reg))
        else $error("state moved after stop");

endmodule

>>> sv/log_frame_replay_checker.sv
`timescale 1ns / 1ps
// Log frame replay checker: a byte accepted on s_valid/s_ready passes the input register,
// then the single-pass deframe stage into the result queue, before its first result word
// shows on m_valid. Throughput is one region byte per cycle while the queue has room;
// the deframe stage and a 4-entry result queue that must hold two free slots per byte set
// it. A frame-good plus stop pair drains 1/cycle while m_ready is high.
// Reset (aresetn low, synchronous) clears the config and state registers to 0, the CRC to all ones,
// the phase to expecting magic and empties the result queue.
module log_frame_replay_checker
    import lfrc_pkg::*;
#(
    parameter int RES_DEPTH = LFRC_RES_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // Input words
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_region_byte,
    // Result words
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_payload_byte,
    output logic [39:0] m_frame_seq,
    output logic [1:0]  m_stop_reason,
    output logic [39:0] m_good_frames,
    output logic [39:0] m_resume_offset,
    output logic        m_last
);

    cfg_t       cfg;
    logic       room2;
    logic [1:0] push_cnt;
    res_t       res0, res1, m_data;

    lfrc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lfrc_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_region_byte (s_region_byte),
        .room2         (room2),
        .push_cnt      (push_cnt),
        .res0          (res0),
        .res1          (res1)
    );

    lfrc_res_fifo #(
        .DEPTH (RES_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_cnt   (push_cnt),
        .push_data0 (res0),
        .push_data1 (res1),
        .room2      (room2),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    // Unpack the head result word
    assign m_kind          = m_data.kind;
    assign m_payload_byte  = m_data.payload_byte;
    assign m_frame_seq     = m_data.frame_seq;
    assign m_stop_reason   = m_data.stop_reason;
    assign m_good_frames   = m_data.good_frames;
    assign m_resume_offset = m_data.resume_offset;
    assign m_last          = m_data.last;

endmodule
